// ===== hdl/dtpw_pkg.sv =====
// shared types and constants for the depth tested pixel write unit
package dtpw_pkg;

	localparam int unsigned PIXELS_DEF       = 65536;
	localparam int unsigned DEPTH_BITS_DEF   = 24;
	localparam int unsigned CHANNEL_BITS_DEF = 16;
	localparam int unsigned SAMPLES          = 4;

	localparam logic [1:0] MODE_DEPTH = 2'd0;
	localparam logic [1:0] MODE_COLOR = 2'd1;
	localparam logic [1:0] MODE_COVER = 2'd2;
	localparam logic [1:0] MODE_BLEND = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] pixel_index;
		logic [23:0] frag_depth;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha_or_cover;
	} frag_t;

	typedef struct packed {
		logic       depth_passed;
		logic       written;
		logic [1:0] replaced_slot;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} state_t;

endpackage

// ===== hdl/depth_tested_pixel_write_unit.sv =====
// depth tested pixel write unit: per-pixel stores with read, modify and write back
// sequence: the start beat is taken in idle, then a read state, then a write state that
// computes and writes back, after which done marks the result beat
// a new fragment is taken only in idle, once the single read-modify-write pass
// through the per-pixel memories is over (busy is high until then); the receiver cannot stall
// reset: all stores are swept to zero, one pixel a cycle, once arst_n rises;
// busy stays high during the sweep; oit_enable resets to 0
module depth_tested_pixel_write_unit #(
	parameter int unsigned PIXELS       = dtpw_pkg::PIXELS_DEF,
	parameter int unsigned DEPTH_BITS   = dtpw_pkg::DEPTH_BITS_DEF,
	parameter int unsigned CHANNEL_BITS = dtpw_pkg::CHANNEL_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dtpw_pkg::frag_t   frag,
	output logic              done,
	output dtpw_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	import dtpw_pkg::*;

	localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int unsigned DB = DEPTH_BITS;
	localparam int unsigned CB = CHANNEL_BITS;
	localparam logic [CB-1:0] CMAX = {CB{1'b1}};
	localparam int unsigned NB = 2 * CB + 1;

	// stores
	logic [DB-1:0]   depth_mem [PIXELS];
	logic [3*CB-1:0] color_mem [PIXELS];
	logic [4*CB-1:0] cover_mem [PIXELS];
	logic [4*CB-1:0] oitc_mem  [PIXELS];
	logic [4*CB-1:0] oitc1_mem [PIXELS];
	logic [4*CB-1:0] oitc2_mem [PIXELS];
	logic [4*CB-1:0] oitc3_mem [PIXELS];
	logic [4*DB-1:0] oitd_mem  [PIXELS];

	state_t state_q, state_d;
	logic [AW:0] clr_q;
	logic oit_enable_q;
	frag_t frag_q;
	logic in_range_q;

	// read data
	logic [DB-1:0]   depth_rd;
	logic [3*CB-1:0] color_rd;
	logic [4*CB-1:0] cover_rd;
	logic [4*DB-1:0] oitd_rd;

	// trimmed fields
	logic [DB-1:0] f_depth;
	logic [CB-1:0] f_r, f_g, f_b, f_a;
	assign f_depth = DB'(frag_q.frag_depth);
	assign f_r = CB'(frag_q.red);
	assign f_g = CB'(frag_q.green);
	assign f_b = CB'(frag_q.blue);
	assign f_a = CB'(frag_q.alpha_or_cover);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oit_enable_q <= 1'b0;
		end else if (cfg_we) begin
			oit_enable_q <= cfg_wdata;
		end
	end

	// state register and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == (AW+1)'(PIXELS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_READ;
			ST_READ:  state_d = ST_WRITE;
			ST_WRITE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// capture the input beat
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			frag_q     <= frag;
			in_range_q <= (32'(frag.pixel_index) < PIXELS);
		end
	end

	logic [AW-1:0] addr;
	assign addr = AW'(frag_q.pixel_index);

	// memory reads
	always_ff @(posedge clk) begin
		depth_rd <= depth_mem[addr];
		color_rd <= color_mem[addr];
		cover_rd <= cover_mem[addr];
		oitd_rd  <= oitd_mem[addr];
	end

	// blend numerators, one multiply pair per channel
	logic [NB-1:0] num_r, num_g, num_b;
	logic [CB-1:0] inv_a;
	assign inv_a = CMAX - f_a;
	assign num_r = NB'(f_r) * NB'(f_a) + NB'(color_rd[3*CB-1:2*CB]) * NB'(inv_a)
		+ NB'(CMAX >> 1);
	assign num_g = NB'(f_g) * NB'(f_a) + NB'(color_rd[2*CB-1:CB]) * NB'(inv_a)
		+ NB'(CMAX >> 1);
	assign num_b = NB'(f_b) * NB'(f_a) + NB'(color_rd[CB-1:0]) * NB'(inv_a)
		+ NB'(CMAX >> 1);

	// divide by 2^CB-1: q = (n + (n >> CB) + 1) >> CB is exact for n < 2^(2CB) - 1
	function automatic logic [CB-1:0] div_cmax(input logic [NB-1:0] n);
		logic [NB:0] t;
		t = {1'b0, n} + (NB+1)'(n >> CB) + (NB+1)'(1);
		return CB'(t >> CB);
	endfunction

	// depth test and sample choice
	logic passed;
	logic [DB-1:0] d0, d1, d2, d3, di, dj;
	logic [1:0] si, sj, slot;
	always_comb begin
		d0 = oitd_rd[DB-1:0];
		d1 = oitd_rd[2*DB-1:DB];
		d2 = oitd_rd[3*DB-1:2*DB];
		d3 = oitd_rd[4*DB-1:3*DB];
		passed = in_range_q && (f_depth >= depth_rd);
		si = (d0 < d1) ? 2'd0 : 2'd1;
		di = (d0 < d1) ? d0 : d1;
		sj = (d2 < d3) ? 2'd2 : 2'd3;
		dj = (d2 < d3) ? d2 : d3;
		slot = (di < dj) ? si : sj;
	end

	logic do_depth, do_color, do_cover, do_blend, do_oit, wr_any;
	always_comb begin
		do_depth = passed && frag_q.mode == MODE_DEPTH;
		do_color = passed && frag_q.mode == MODE_COLOR;
		do_cover = passed && frag_q.mode == MODE_COVER && f_a >= cover_rd[CB-1:0];
		do_blend = passed && frag_q.mode == MODE_BLEND && f_a != '0 && !oit_enable_q;
		do_oit   = passed && frag_q.mode == MODE_BLEND && f_a != '0 && oit_enable_q;
		wr_any   = do_depth || do_color || do_cover || do_blend || do_oit;
	end

	logic [4*DB-1:0] oitd_new;
	always_comb begin
		oitd_new = oitd_rd;
		case (slot)
			2'd0: oitd_new[DB-1:0]      = f_depth;
			2'd1: oitd_new[2*DB-1:DB]   = f_depth;
			2'd2: oitd_new[3*DB-1:2*DB] = f_depth;
			default: oitd_new[4*DB-1:3*DB] = f_depth;
		endcase
	end

	// memory writes, clearing sweep after reset
	logic clr;
	logic [AW-1:0] waddr;
	logic wr;
	assign clr   = (state_q == ST_CLEAR);
	assign wr    = (state_q == ST_WRITE);
	assign waddr = clr ? AW'(clr_q) : addr;
	always_ff @(posedge clk) begin
		if (clr) begin
			depth_mem[waddr] <= '0;
			color_mem[waddr] <= '0;
			cover_mem[waddr] <= '0;
			oitc_mem[waddr]  <= '0;
			oitc1_mem[waddr] <= '0;
			oitc2_mem[waddr] <= '0;
			oitc3_mem[waddr] <= '0;
			oitd_mem[waddr]  <= '0;
		end else if (wr) begin
			if (do_depth) depth_mem[waddr] <= f_depth;
			if (do_color) color_mem[waddr] <= {f_r, f_g, f_b};
			if (do_blend) begin
				color_mem[waddr] <= {div_cmax(num_r), div_cmax(num_g), div_cmax(num_b)};
			end
			if (do_cover) cover_mem[waddr] <= {f_r, f_g, f_b, f_a};
			if (do_oit) begin
				oitd_mem[waddr] <= oitd_new;
				if (slot == 2'd0) oitc_mem[waddr]  <= {f_r, f_g, f_b, f_a};
				if (slot == 2'd1) oitc1_mem[waddr] <= {f_r, f_g, f_b, f_a};
				if (slot == 2'd2) oitc2_mem[waddr] <= {f_r, f_g, f_b, f_a};
				if (slot == 2'd3) oitc3_mem[waddr] <= {f_r, f_g, f_b, f_a};
			end
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= wr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			result.depth_passed  <= passed;
			result.written       <= wr_any;
			result.replaced_slot <= do_oit ? slot : 2'd0;
		end
	end

endmodule

// ===== hdl/dtpw_checker.sv =====
// port-level checker for the depth tested pixel write unit, bound to the top level
module dtpw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input dtpw_pkg::result_t result
);
	import dtpw_pkg::*;

	// a start beat leaves the unit busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start beat not taken");

	// a result beat follows its start beat after the read and write states
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##2 done) else $error("result beat missing");

	// a result beat lasts one cycle
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("repeated result beat");

	// a written fragment always passed the depth test
	a_written_passed: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.written |-> result.depth_passed) else $error("write without pass");

	// a replaced slot implies a write
	a_slot_written: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.replaced_slot != 2'd0 |-> result.written)
		else $error("slot without write");

endmodule

bind depth_tested_pixel_write_unit dtpw_checker u_dtpw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== dv/tb_depth_tested_pixel_write_unit.sv =====
// testbench for the depth tested pixel write unit: directed table, then random fragments
`timescale 1ns / 1ps

module tb_depth_tested_pixel_write_unit;
	import dtpw_pkg::*;

	localparam int unsigned N_PIX    = 65536;
	localparam int unsigned MAX_SHOW = 10;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	frag_t   frag;
	logic    done;
	result_t result;
	logic    cfg_we;
	logic    cfg_wdata;

	depth_tested_pixel_write_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.frag      (frag),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the pixel stores
	bit [23:0] depth_mem [N_PIX];
	bit [47:0] color_mem [N_PIX];
	bit [63:0] cover_mem [N_PIX];
	bit [63:0] oit_color_mem [N_PIX*SAMPLES];
	bit [23:0] oit_depth_mem [N_PIX*SAMPLES];
	bit        oit_on;

	result_t pending_results [$];
	int      mismatches;
	int      frags_sent;
	int      results_seen;
	int      blends_oit;
	int      blends_color;

	typedef struct {
		bit      is_cfg;
		bit      cfg_val;
		frag_t   f;
		bit      typed;
		result_t r;
	} row_t;

	row_t plan [$];

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// rounded alpha blend of one channel
	function automatic bit [15:0] mix_channel(bit [15:0] src, bit [15:0] dst, bit [15:0] a);
		bit [63:0] num;
		num = 64'(src) * 64'(a) + 64'(dst) * 64'(16'hFFFF - a) + 64'd32767;
		return 16'(num / 64'd65535);
	endfunction

	// apply one fragment to the shadow stores and return its outcome
	function automatic result_t apply_fragment(frag_t f);
		result_t   r;
		int        p;
		int        base;
		int        i;
		int        j;
		int        k;
		bit [47:0] c;
		r = '0;
		p = int'(f.pixel_index);
		r.depth_passed = (f.frag_depth >= depth_mem[p]);
		if (r.depth_passed) begin
			case (f.mode)
				MODE_DEPTH: begin
					depth_mem[p] = f.frag_depth;
					r.written = 1'b1;
				end
				MODE_COLOR: begin
					color_mem[p] = {f.red, f.green, f.blue};
					r.written = 1'b1;
				end
				MODE_COVER: begin
					if (f.alpha_or_cover >= cover_mem[p][15:0]) begin
						cover_mem[p] = {f.red, f.green, f.blue, f.alpha_or_cover};
						r.written = 1'b1;
					end
				end
				default: begin
					if (f.alpha_or_cover != 16'd0) begin
						if (oit_on) begin
							base = p * SAMPLES;
							i = (oit_depth_mem[base] < oit_depth_mem[base+1]) ? 0 : 1;
							j = (oit_depth_mem[base+2] < oit_depth_mem[base+3]) ? 2 : 3;
							k = (oit_depth_mem[base+i] < oit_depth_mem[base+j]) ? i : j;
							oit_color_mem[base+k] = {f.red, f.green, f.blue, f.alpha_or_cover};
							oit_depth_mem[base+k] = f.frag_depth;
							r.replaced_slot = 2'(k);
							blends_oit++;
						end else begin
							c = color_mem[p];
							color_mem[p] = {mix_channel(f.red, c[47:32], f.alpha_or_cover),
								mix_channel(f.green, c[31:16], f.alpha_or_cover),
								mix_channel(f.blue, c[15:0], f.alpha_or_cover)};
							blends_color++;
						end
						r.written = 1'b1;
					end
				end
			endcase
		end
		return r;
	endfunction

	// present one fragment and hold it until accepted
	task automatic send_fragment(frag_t f, bit typed, result_t r);
		result_t want;
		frag  <= f;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		want = apply_fragment(f);
		pending_results.push_back(typed ? r : want);
		frags_sent++;
	endtask

	// program oit_enable once the block has drained
	task automatic set_oit(bit v);
		start <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (6) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		oit_on = v;
	endtask

	function automatic frag_t mk(bit [1:0] m, bit [15:0] p, bit [23:0] d,
			bit [15:0] cr, bit [15:0] cg, bit [15:0] cb, bit [15:0] a);
		frag_t f;
		f.mode = m;
		f.pixel_index = p;
		f.frag_depth = d;
		f.red = cr;
		f.green = cg;
		f.blue = cb;
		f.alpha_or_cover = a;
		return f;
	endfunction

	function automatic void add_row(frag_t f, bit typed, bit dp, bit wr, bit [1:0] sl);
		row_t rw;
		rw.is_cfg = 1'b0;
		rw.cfg_val = 1'b0;
		rw.f = f;
		rw.typed = typed;
		rw.r.depth_passed = dp;
		rw.r.written = wr;
		rw.r.replaced_slot = sl;
		plan.push_back(rw);
	endfunction

	function automatic void add_cfg(bit v);
		row_t rw;
		rw = '{default: '0};
		rw.is_cfg = 1'b1;
		rw.cfg_val = v;
		plan.push_back(rw);
	endfunction

	// random fragment, mostly aimed at a few hot pixels so stores get reused
	function automatic frag_t random_fragment();
		bit [15:0] hot [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h1234,
			16'h8000, 16'h5555, 16'hFFFE, 16'hFFFF};
		frag_t f;
		int    pick;
		f.mode = 2'($urandom_range(0, 3));
		f.pixel_index = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 7)]
			: 16'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			f.frag_depth = 24'd0;
		else if (pick == 1)
			f.frag_depth = 24'hFFFFFF;
		else if (pick < 6)
			f.frag_depth = 24'($urandom_range(24'hFFFFFF - 4095, 24'hFFFFFF));
		else
			f.frag_depth = 24'($urandom);
		f.red = 16'($urandom);
		f.green = 16'($urandom);
		f.blue = 16'($urandom);
		pick = $urandom_range(0, 5);
		if (pick == 0)
			f.alpha_or_cover = 16'd0;
		else if (pick == 1)
			f.alpha_or_cover = 16'hFFFF;
		else if (pick == 2)
			f.alpha_or_cover = 16'd1;
		else
			f.alpha_or_cover = 16'($urandom);
		return f;
	endfunction

	// result checker: the receiver always takes the beat
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOW)
					$display("ERROR %0t: result beat with nothing pending: %p", $realtime, result);
			end else begin
				want = pending_results.pop_front();
				if (result.depth_passed !== want.depth_passed || result.written !== want.written
						|| result.replaced_slot !== want.replaced_slot) begin
					mismatches++;
					if (mismatches <= MAX_SHOW)
						$display("ERROR %0t: expected pass=%0b wr=%0b slot=%0d, got pass=%0b wr=%0b slot=%0d",
							$realtime, want.depth_passed, want.written, want.replaced_slot,
							result.depth_passed, result.written, result.replaced_slot);
				end
			end
		end
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// main sequence
	initial begin
		result_t none;
		int      burst;
		int      gap;
		int      left;
		bit      calm;
		none = '0;
		clk = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		frag <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		oit_on = 1'b0;
		mismatches = 0;
		frags_sent = 0;
		results_seen = 0;
		blends_oit = 0;
		blends_color = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows: extremes, every mode, zero alpha, depth fail, slot order
		add_row(mk(MODE_DEPTH, 16'd5, 24'd0, 0, 0, 0, 0), 1, 1, 1, 0);
		add_row(mk(MODE_DEPTH, 16'd5, 24'hFFFFFF, 0, 0, 0, 0), 1, 1, 1, 0);
		add_row(mk(MODE_COLOR, 16'd5, 24'hFFFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1, 0, 0, 0);
		add_row(mk(MODE_COLOR, 16'd5, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1, 1, 1, 0);
		add_row(mk(MODE_COVER, 16'd5, 24'hFFFFFF, 16'h1111, 16'h2222, 16'h3333, 0), 1, 1, 1, 0);
		add_row(mk(MODE_COVER, 16'd6, 24'd0, 16'hFFFF, 0, 16'hFFFF, 16'hFFFF), 1, 1, 1, 0);
		add_row(mk(MODE_COVER, 16'd6, 24'd0, 16'h1234, 0, 0, 16'd1), 1, 1, 0, 0);
		add_row(mk(MODE_COVER, 16'd6, 24'd0, 16'h4321, 0, 0, 16'hFFFF), 1, 1, 1, 0);
		add_row(mk(MODE_BLEND, 16'd7, 24'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1, 1, 0, 0);
		add_row(mk(MODE_BLEND, 16'd7, 24'd0, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFF), 1, 1, 1, 0);
		add_row(mk(MODE_BLEND, 16'd7, 24'd3, 16'h0000, 16'hFFFF, 16'h7FFF, 16'd1), 0, 0, 0, 0);
		add_row(mk(MODE_BLEND, 16'd7, 24'd3, 16'h1357, 16'h0001, 16'hFFFE, 16'h8000), 0, 0, 0, 0);
		add_row(mk(MODE_BLEND, 16'd5, 24'd0, 16'hFFFF, 0, 0, 16'hFFFF), 1, 0, 0, 0);
		add_row(mk(MODE_COLOR, 16'hFFFF, 24'hFFFFFF, 16'hAAAA, 16'h5555, 16'hFFFF, 0), 1, 1, 1, 0);
		add_cfg(1'b1);
		add_row(mk(MODE_BLEND, 16'd9, 24'h10, 16'h1, 16'h2, 16'h3, 16'd5), 1, 1, 1, 3);
		add_row(mk(MODE_BLEND, 16'd9, 24'h20, 16'h4, 16'h5, 16'h6, 16'd5), 1, 1, 1, 2);
		add_row(mk(MODE_BLEND, 16'd9, 24'h30, 16'h7, 16'h8, 16'h9, 16'd5), 1, 1, 1, 1);
		add_row(mk(MODE_BLEND, 16'd9, 24'h40, 16'hA, 16'hB, 16'hC, 16'd5), 1, 1, 1, 0);
		add_row(mk(MODE_BLEND, 16'd9, 24'h05, 16'hD, 16'hE, 16'hF, 16'd0), 1, 1, 0, 0);
		add_row(mk(MODE_BLEND, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			0, 0, 0, 0);
		add_row(mk(MODE_BLEND, 16'd5, 24'd1, 16'hFFFF, 0, 0, 16'hFFFF), 1, 0, 0, 0);
		add_cfg(1'b0);

		foreach (plan[n]) begin
			if (plan[n].is_cfg)
				set_oit(plan[n].cfg_val);
			else
				send_fragment(plan[n].f, plan[n].typed, plan[n].r);
		end

		// random phases, flipping oit_enable between them
		for (int ph = 0; ph < 8; ph++) begin
			set_oit(ph[0]);
			left = 210;
			calm = (ph % 3 == 2);
			while (left > 0) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && left > 0; b++) begin
					send_fragment(random_fragment(), 0, none);
					left--;
				end
				gap = calm ? 0 : $urandom_range(0, 7);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		start <= 1'b0;

		// drain
		wait (pending_results.size() == 0);
		repeat (10) @(posedge clk);
		$display("Sent %0d fragments, checked %0d results across both oit_enable settings",
			frags_sent, results_seen);
		$display("Blends into transparency samples: %0d, into color: %0d, mismatches: %0d",
			blends_oit, blends_color, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
